// File: rtl/core/positional_array_list_engine_core_macros.svh
// Assertion macros for the positional array list engine.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PALE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PALE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pale_pkg.sv
// Shared types and constants of the positional array list engine.
// No dependencies; imported by every module of the block.
package pale_pkg;

    localparam int MODE_W    = 2;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 3;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int DEPTH_DEF = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRAVERSE = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SRCH,
        S_TRAV,
        S_TEMIT,
        S_RES
    } t_state;

    // One result as presented on the output channel
    typedef struct packed {
        t_status                  status;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] element;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } t_result;

    // Flags from the shared index/compare unit
    typedef struct packed {
        logic match;
        logic at_bound;
        logic next_at_bound;
    } t_step_flags;

endpackage

// File: rtl/core/pale_mem.sv
// Entry storage: one write port and one registered read port.
// Depends on pale_pkg for the data width.
module pale_mem import pale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pale_step.sv
// Shared index and compare unit: steps the walk index and tests bounds and keys.
// Depends on pale_pkg for the data width and the flag struct.
module pale_step import pale_pkg::*; #(
    parameter int CW = 7
) (
    input  logic [CW-1:0]     i_idx,
    input  logic [CW-1:0]     i_bound,
    input  logic              i_down,
    input  logic [DATA_W-1:0] i_rdata,
    input  logic [DATA_W-1:0] i_key,
    output logic [CW-1:0]     o_next,
    output t_step_flags       o_flags
);

    // Step the index one place up or down
    assign o_next = i_down ? (i_idx - CW'(1)) : (i_idx + CW'(1));

    // Compare against the walk bound and the search key
    assign o_flags.at_bound      = (i_idx == i_bound);
    assign o_flags.next_at_bound = (o_next == i_bound);
    assign o_flags.match         = (i_rdata == i_key);

endmodule

// File: rtl/core/pale_ctrl.sv
// Sequencer: decodes a request, walks the entry memory one step a cycle unless the output stalls it.
// Depends on pale_pkg; drives pale_mem and uses pale_step for each step.
module pale_ctrl import pale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_search_key,
    input  logic                     i_slot_free,
    output logic                     o_emit,
    output t_result                  o_result,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic [DATA_W-1:0]        o_mem_wdata,
    output logic                     o_mem_re,
    output logic [AW-1:0]            o_mem_raddr,
    input  logic [DATA_W-1:0]        i_mem_rdata
);

    localparam int PW = (POS_W > CW) ? POS_W : CW;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_wpend, n_wpend;
    logic [AW-1:0]     r_wad, n_wad;
    logic              r_rpend, n_rpend;
    logic [AW-1:0]     r_ridx, n_ridx;
    logic [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0] r_value, n_value;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_index, n_index;

    logic              accept;
    logic              ins_bad, ins_full, del_bad, cnt_zero;
    logic              step_down;
    logic [CW-1:0]     step_bound;
    logic [CW-1:0]     step_next;
    t_step_flags       flags;

    // Request checks against the current count
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign ins_bad  = PW'(i_position) > PW'(r_cnt);
    assign del_bad  = PW'(i_position) >= PW'(r_cnt);
    assign ins_full = (r_cnt == CW'(DEPTH));
    assign cnt_zero = (r_cnt == '0);

    // Insert walks down to the position, all others walk up to the count
    assign step_down  = (r_state == S_INS);
    assign step_bound = (r_state == S_INS) ? r_pos : r_cnt;

    pale_step #(
        .CW (CW)
    ) u_step (
        .i_idx   (r_idx),
        .i_bound (step_bound),
        .i_down  (step_down),
        .i_rdata (i_mem_rdata),
        .i_key   (r_key),
        .o_next  (step_next),
        .o_flags (flags)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_INSERT:   n_state = (ins_bad || ins_full) ? S_RES : S_INS;
                        MODE_DELETE:   n_state = del_bad ? S_RES : S_DEL;
                        MODE_SEARCH:   n_state = S_SRCH;
                        MODE_TRAVERSE: n_state = cnt_zero ? S_RES : S_TRAV;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (!r_wpend && flags.at_bound) n_state = S_RES;
            end
            S_DEL: begin
                if (!r_wpend && flags.next_at_bound) n_state = S_RES;
            end
            S_SRCH: begin
                if ((r_rpend && flags.match) || flags.at_bound) n_state = S_RES;
            end
            S_TRAV: n_state = S_TEMIT;
            S_TEMIT: begin
                if (i_slot_free && flags.next_at_bound) n_state = S_IDLE;
            end
            S_RES: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_wpend     = r_wpend;
        n_wad       = r_wad;
        n_rpend     = r_rpend;
        n_ridx      = r_ridx;
        n_key       = r_key;
        n_value     = r_value;
        n_status    = r_status;
        n_index     = r_index;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wad;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        o_emit      = 1'b0;
        o_result    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key    = i_search_key;
                    n_value  = i_value;
                    n_pos    = CW'(i_position);
                    n_wpend  = 1'b0;
                    n_rpend  = 1'b0;
                    n_index  = '0;
                    n_status = ST_OK;
                    unique case (t_mode'(i_mode))
                        MODE_INSERT: begin
                            n_idx = r_cnt;
                            if (ins_bad) begin
                                n_status = ST_BADPOS;
                            end else if (ins_full) begin
                                n_status = ST_FULL;
                            end
                        end
                        MODE_DELETE: begin
                            n_idx = CW'(i_position);
                            if (del_bad) n_status = ST_BADPOS;
                        end
                        MODE_SEARCH: n_idx = '0;
                        MODE_TRAVERSE: begin
                            n_idx = '0;
                            if (cnt_zero) n_status = ST_EMPTY;
                        end
                        default: n_idx = '0;
                    endcase
                end
            end
            S_INS: begin
                // Read the entry below, write it one place up next cycle
                if (!flags.at_bound) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = step_next[AW-1:0];
                    n_wpend     = 1'b1;
                    n_wad       = r_idx[AW-1:0];
                    n_idx       = step_next;
                end else begin
                    n_wpend = 1'b0;
                end
                if (r_wpend) begin
                    o_mem_we = 1'b1;
                end else if (flags.at_bound) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pos[AW-1:0];
                    o_mem_wdata = r_value;
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            S_DEL: begin
                // Read the entry above, write it one place down next cycle
                if (!flags.next_at_bound) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = step_next[AW-1:0];
                    n_wpend     = 1'b1;
                    n_wad       = r_idx[AW-1:0];
                    n_idx       = step_next;
                end else begin
                    n_wpend = 1'b0;
                end
                if (r_wpend) begin
                    o_mem_we = 1'b1;
                end else if (flags.next_at_bound) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_SRCH: begin
                // Compare the word read last cycle while fetching the next
                if (r_rpend && flags.match) begin
                    n_status = ST_OK;
                    n_index  = IDX_W'(r_ridx);
                end else if (!flags.at_bound) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx[AW-1:0];
                    n_rpend     = 1'b1;
                    n_ridx      = r_idx[AW-1:0];
                    n_idx       = step_next;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_index  = '0;
                end
            end
            S_TRAV: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_idx[AW-1:0];
            end
            S_TEMIT: begin
                // Emit the held word, then fetch the next one
                if (i_slot_free) begin
                    o_emit           = 1'b1;
                    o_result.status  = ST_OK;
                    o_result.index   = IDX_W'(r_idx);
                    o_result.element = i_mem_rdata;
                    o_result.count   = CNT_W'(r_cnt);
                    o_result.last    = flags.next_at_bound;
                    if (!flags.next_at_bound) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = step_next[AW-1:0];
                        n_idx       = step_next;
                    end
                end
            end
            S_RES: begin
                if (i_slot_free) begin
                    o_emit           = 1'b1;
                    o_result.status  = r_status;
                    o_result.index   = r_index;
                    o_result.element = '0;
                    o_result.count   = CNT_W'(r_cnt);
                    o_result.last    = 1'b1;
                end
            end
            default: begin
                n_wpend = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wpend <= 1'b0;
            r_rpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wpend <= n_wpend;
            r_rpend <= n_rpend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_wad    <= n_wad;
        r_ridx   <= n_ridx;
        r_key    <= n_key;
        r_value  <= n_value;
        r_status <= n_status;
        r_index  <= n_index;
    end

endmodule

// File: rtl/core/positional_array_list_engine_core.sv
// Top level of the positional array list engine: sequencer, memory, output register.
// Depends on pale_pkg, pale_ctrl, pale_step, pale_mem and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: mode (insert,
//   delete, search, traverse), position, value and search key. The block takes
//   one request at a time; o_in_stall stays high until its last result is handed
//   to the output register.
//   Output channel (o_out_valid / i_out_stall) carries results; o_last marks the
//   final result of a request. Insert, delete and search give one result each,
//   traverse gives one per entry (one empty status on an empty list).
//   Traverse emits one entry per cycle after the first while the receiver
//   does not stall. The next request is taken in the cycle after the last
//   result is emitted. Every step goes through the single read and single
//   write port of the entry memory, whose read data is registered; that port
//   paces each walk. Reset empties the list at once; no clearing pass runs.
//   While the receiver stalls, the output register holds its result and the
//   sequencer waits to emit its next result.
`include "positional_array_list_engine_core_macros.svh"
module positional_array_list_engine_core import pale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_search_key,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic [IDX_W-1:0]         o_index,
    output logic signed [DATA_W-1:0] o_element,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              slot_free;
    logic              emit;
    t_result           result;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              r_out_valid;
    t_result           r_out;
    logic              in_accept;
    logic              out_mid;
    logic              out_empty;

    // Output register frees when empty or taken this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    pale_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_search_key (i_search_key),
        .i_slot_free  (slot_free),
        .o_emit       (emit),
        .o_result     (result),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    pale_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output valid: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_index     = r_out.index;
    assign o_element   = r_out.element;
    assign o_count     = r_out.count;
    assign o_last      = r_out.last;

    // Watch points for the checks
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_mid   = o_out_valid && !o_last;
    assign out_empty = o_out_valid && (o_status == ST_EMPTY);

    // Checks on the sequencer and the output register
    `PALE_ASSERT_NEXT(a_busy_after_accept, in_accept, o_in_stall, "block idle after a request")
    `PALE_ASSERT_NOW(a_emit_into_free_slot, emit, slot_free, "emit into a held result")
    `PALE_ASSERT_NOW(a_non_final_is_entry, out_mid, o_status == ST_OK, "non-final result not ok")
    `PALE_ASSERT_NOW(a_empty_status_shape, out_empty, o_last && o_count == '0, "bad empty status")

endmodule
